>>> sv/ali_pkg.sv
// Shared types and constants for the bounded array list block.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ali_pkg;

    // Most entries the list holds (2..32).
    localparam int unsigned CAPACITY = 32;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned LEN_W  = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CMP_W  = (LEN_W > IDX_W) ? LEN_W : IDX_W;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_DUMP   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]              operation;
        logic [IDX_W-1:0]        index;
        logic signed [DATA_W-1:0] value;
    } ali_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic [IDX_W-1:0]         position;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } ali_out_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PUT   = 6'b001000,
        S_DUMP  = 6'b010000,
        S_RESP  = 6'b100000
    } ali_state_t;

endpackage

`default_nettype wire

>>> sv/ali_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ali_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds until the next read is issued.
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/array_list_insert_delete.sv
// Top level of the bounded ordered list of signed 32-bit values.
// Depends on ali_pkg and on the generic RAM ali_ram.
//
// Usage: each beat on the s_ channel (s_valid/s_ready, payload s_data) carries one
// operation: append, set, insert, delete or dump. Each beat on the m_ channel
// (m_valid/m_ready, payload m_data) carries one result. Every operation gives one
// result with last set, except a dump of a non-empty list, which gives one result
// per element in order, with last set on the final one.
// The elements live in a single RAM with a registered read port; the length is a
// register. s_ready is high only while the controller is idle. Append, set, delete
// of the final entry and every error go from the accepted beat straight to the
// response state; insert and delete move one entry per cycle through the RAM port,
// then an insert writes the new value at its index. A dump reads the elements in
// order and streams one element per cycle while the receiver takes results.
// Results leave through an output register, so the next beat is accepted while a
// result still waits for m_ready. When the receiver stalls, the output register
// holds its beat and the controller waits; no result is lost or repeated.
// Reset gives an empty list; RAM contents are not cleared, and only entries below
// the length are ever read.
`timescale 1ns / 1ps
`default_nettype none

module array_list_insert_delete
    import ali_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ali_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ali_out_t      m_data
);

    ali_state_t  state_reg, state_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  ptr_reg, ptr_next;
    logic [LEN_W-1:0]  end_reg, end_next;
    logic              up_reg, up_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              have_reg, have_next;
    ali_out_t          res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    ali_out_t          m_data_reg, m_data_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic slot_free;
    logic accept;
    logic in_range;
    logic full;
    logic last_elem;

    ali_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign in_range  = CMP_W'(s_data.index) < CMP_W'(length_reg);
    assign full      = (length_reg == LEN_W'(CAPACITY));
    assign last_elem = (ptr_reg == length_reg);
    assign rd_addr   = ptr_reg[ADDR_W-1:0];

    always_comb begin
        state_next     = state_reg;
        length_next    = length_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        have_next      = have_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next.status   = ST_OK;
                    res_next.element  = '0;
                    res_next.position = '0;
                    res_next.count    = CNT_W'(length_reg);
                    res_next.last     = 1'b1;
                    idx_next          = ADDR_W'(s_data.index);
                    val_next          = s_data.value;
                    state_next        = S_RESP;
                    priority if (s_data.operation == OP_APPEND) begin
                        if (full) begin
                            res_next.status = ST_FULL;
                        end else begin
                            wr_en          = 1'b1;
                            wr_addr        = length_reg[ADDR_W-1:0];
                            wr_data        = s_data.value;
                            length_next    = length_reg + 1'b1;
                            res_next.count = CNT_W'(length_reg + 1'b1);
                        end
                    end else if (s_data.operation == OP_SET) begin
                        if (!in_range) begin
                            res_next.status = ST_BOUNDS;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = ADDR_W'(s_data.index);
                            wr_data = s_data.value;
                        end
                    end else if (s_data.operation == OP_INSERT) begin
                        if (!in_range) begin
                            res_next.status = ST_BOUNDS;
                        end else if (full) begin
                            res_next.status = ST_FULL;
                        end else begin
                            // Move entries upwards, starting from the top one.
                            ptr_next   = length_reg - 1'b1;
                            end_next   = LEN_W'(s_data.index);
                            up_next    = 1'b1;
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end else if (s_data.operation == OP_DELETE) begin
                        if (!in_range) begin
                            res_next.status = ST_BOUNDS;
                        end else if (LEN_W'(s_data.index) == length_reg - 1'b1) begin
                            // Removing the final entry moves nothing.
                            length_next    = length_reg - 1'b1;
                            res_next.count = CNT_W'(length_reg - 1'b1);
                        end else begin
                            ptr_next   = LEN_W'(s_data.index) + 1'b1;
                            end_next   = length_reg - 1'b1;
                            up_next    = 1'b0;
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end else if (s_data.operation == OP_DUMP) begin
                        if (length_reg == '0) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            ptr_next   = '0;
                            have_next  = 1'b0;
                            state_next = S_DUMP;
                        end
                    end else begin
                        res_next.status = ST_OK;
                    end
                end
            end

            S_SHIFT: begin
                // Read one entry per cycle; the entry read last cycle is written
                // one place up or down. Read and write addresses never coincide.
                rd_en          = 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg[ADDR_W-1:0];
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = up_reg ? pend_addr_reg + 1'b1 : pend_addr_reg - 1'b1;
                    wr_data = rd_data;
                end
                if (ptr_reg == end_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    ptr_next = up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                end
            end

            S_DRAIN: begin
                wr_en     = 1'b1;
                wr_addr   = up_reg ? pend_addr_reg + 1'b1 : pend_addr_reg - 1'b1;
                wr_data   = rd_data;
                pend_next = 1'b0;
                if (up_reg) begin
                    state_next = S_PUT;
                end else begin
                    length_next    = length_reg - 1'b1;
                    res_next.count = CNT_W'(length_reg - 1'b1);
                    state_next     = S_RESP;
                end
            end

            S_PUT: begin
                wr_en          = 1'b1;
                wr_addr        = idx_reg;
                wr_data        = val_reg;
                length_next    = length_reg + 1'b1;
                res_next.count = CNT_W'(length_reg + 1'b1);
                state_next     = S_RESP;
            end

            S_DUMP: begin
                // The RAM output holds the element at ptr_reg - 1 while have_reg.
                if (have_reg && slot_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.status   = ST_OK;
                    m_data_next.element  = rd_data;
                    m_data_next.position = IDX_W'(ptr_reg - 1'b1);
                    m_data_next.count    = CNT_W'(length_reg);
                    m_data_next.last     = last_elem;
                    have_next            = 1'b0;
                    if (last_elem) begin
                        state_next = S_IDLE;
                    end
                end
                if (!last_elem && (!have_reg || slot_free)) begin
                    rd_en     = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                    have_next = 1'b1;
                end
            end

            S_RESP: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            length_reg  <= '0;
            pend_reg    <= 1'b0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            length_reg  <= length_next;
            pend_reg    <= pend_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        up_reg        <= up_next;
        pend_addr_reg <= pend_addr_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    // The length never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= LEN_W'(CAPACITY))
        else $error("list length exceeds capacity");

    // The length moves by at most one entry per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (length_reg == $past(length_reg) ||
             length_reg == $past(length_reg) + 1'b1 ||
             length_reg == $past(length_reg) - 1'b1))
        else $error("list length jumped");

    // While entries move, the write never hits the entry being read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && pend_reg) |-> (wr_addr != rd_addr))
        else $error("shift write collides with read");

    // Held read data belongs to a dump in progress only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        have_reg |-> (state_reg == S_DUMP))
        else $error("dump data held outside a dump");

endmodule

`default_nettype wire
